// ----- sv/ctaphid_pkg.sv -----
// ============================================================================
// CTAPHID message reassembler package
// Shared widths, result and error codes, and the command and status records
// that pass between the controller and the datapath.
// ============================================================================
package ctaphid_pkg;

    localparam int COUNT_W   = 8;
    localparam int ELAPSED_W = 17;
    localparam int TIMEOUT_W = 16;
    localparam int LENGTH_W  = 16;
    localparam int CHANNEL_W = 32;
    localparam int INIT_HDR  = 7;
    localparam int CONT_HDR  = 5;
    localparam int HDR_AW    = 3;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] ERR_LENGTH   = 2'd0;
    localparam logic [1:0] ERR_NOT_INIT = 2'd1;
    localparam logic [1:0] ERR_SEQUENCE = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

    typedef struct packed {
        logic       count_clear;
        logic       start_init;
        logic       start_cont;
        logic       go_idle;
        logic       tick_step;
        logic       rd_step;
        logic       load_out;
        logic [1:0] out_kind;
        logic [1:0] out_err;
        logic       out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic len_ok;
        logic collecting;
        logic is_init;
        logic cid_match;
        logic seq_ok;
        logic timeout_hit;
        logic take_zero;
        logic remaining_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/ctaphid_in_if.sv -----
// ============================================================================
// Report input channel
// Carries one received report byte or one millisecond tick per request.
// ============================================================================
interface ctaphid_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] report_byte;
    logic       report_end;

    modport source (output valid, output command, output report_byte, output report_end,
                    input ready);
    modport sink (input valid, input command, input report_byte, input report_end,
                  output ready);
endinterface

// ----- sv/ctaphid_out_if.sv -----
// ============================================================================
// Result output channel
// Carries one payload byte, completion or error result per request.
// ============================================================================
interface ctaphid_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  payload_byte;
    logic [31:0] channel_id;
    logic [7:0]  frame_command;
    logic [15:0] message_length;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output out_kind, output payload_byte, output channel_id,
                    output frame_command, output message_length, output error_code,
                    output last, input ready);
    modport sink (input valid, input out_kind, input payload_byte, input channel_id,
                  input frame_command, input message_length, input error_code,
                  input last, output ready);
endinterface

// ----- sv/ctaphid_datapath.sv -----
// ============================================================================
// CTAPHID reassembler datapath
// Report buffer memory, header capture, message state, tick counter and the
// output register.
// ============================================================================
module ctaphid_datapath
    import ctaphid_pkg::*;
#(
    parameter int REPORT_BYTES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 in_command,
    input  logic [7:0]           in_byte,
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [1:0]           out_kind,
    output logic [7:0]           payload_byte,
    output logic [CHANNEL_W-1:0] channel_id,
    output logic [7:0]           frame_command,
    output logic [LENGTH_W-1:0]  message_length,
    output logic [1:0]           error_code,
    output logic                 last
);

    localparam int AW       = $clog2(REPORT_BYTES);
    localparam int CAP_INIT = REPORT_BYTES - INIT_HDR;
    localparam int CAP_CONT = REPORT_BYTES - CONT_HDR;
    localparam int TW       = $clog2(CAP_CONT + 1);

    logic [7:0]           buffer_mem [REPORT_BYTES];
    logic [7:0]           hdr_reg [INIT_HDR];
    logic [7:0]           rd_data_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 collecting_reg;
    logic [CHANNEL_W-1:0] held_channel_reg;
    logic [7:0]           held_command_reg;
    logic [LENGTH_W-1:0]  held_length_reg;
    logic [LENGTH_W-1:0]  remaining_reg;
    logic [7:0]           seq_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TW-1:0]        take_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [7:0]           payload_byte_reg;
    logic [CHANNEL_W-1:0] channel_id_reg;
    logic [7:0]           frame_command_reg;
    logic [LENGTH_W-1:0]  message_length_reg;
    logic [1:0]           error_code_reg;
    logic                 last_reg;

    logic                 byte_fire;
    logic                 mem_wr;
    logic                 hdr_wr;
    logic [CHANNEL_W-1:0] cid;
    logic [LENGTH_W-1:0]  base_len;
    logic [LENGTH_W-1:0]  cap_len;
    logic [LENGTH_W-1:0]  take_wide;
    logic [TW-1:0]        take_next;
    logic [LENGTH_W-1:0]  remaining_next;
    logic [AW-1:0]        rd_start;
    logic [ELAPSED_W-1:0] elapsed_next;

    assign byte_fire = in_fire && !in_command;
    assign mem_wr    = byte_fire && (count_reg < COUNT_W'(REPORT_BYTES));
    assign hdr_wr    = byte_fire && (count_reg < COUNT_W'(INIT_HDR));
    assign cid       = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};

    assign base_len       = cmd.start_init ? {hdr_reg[5], hdr_reg[6]} : remaining_reg;
    assign cap_len        = cmd.start_init ? LENGTH_W'(CAP_INIT) : LENGTH_W'(CAP_CONT);
    assign take_wide      = (base_len < cap_len) ? base_len : cap_len;
    assign take_next      = take_wide[TW-1:0];
    assign remaining_next = base_len - take_wide;
    assign rd_start       = cmd.start_init ? AW'(INIT_HDR) : AW'(CONT_HDR);
    assign elapsed_next   = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        status.len_ok         = (count_reg == COUNT_W'(REPORT_BYTES));
        status.collecting     = collecting_reg;
        status.is_init        = hdr_reg[4][7];
        status.cid_match      = (cid == held_channel_reg);
        status.seq_ok         = !hdr_reg[4][7] && (hdr_reg[4] == seq_reg);
        status.timeout_hit    = (elapsed_next >= {1'b0, timeout_reg});
        status.take_zero      = (take_reg == '0);
        status.remaining_zero = (remaining_reg == '0);
        status.out_free       = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            buffer_mem[count_reg[AW-1:0]] <= in_byte;
        end
        if (hdr_wr)
        begin
            hdr_reg[count_reg[HDR_AW-1:0]] <= in_byte;
        end
        if (cmd.rd_step)
        begin
            rd_data_reg <= buffer_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            collecting_reg   <= 1'b0;
            held_channel_reg <= '0;
            held_command_reg <= '0;
            held_length_reg  <= '0;
            remaining_reg    <= '0;
            seq_reg          <= '0;
            elapsed_reg      <= '0;
            timeout_reg      <= TIMEOUT_RESET;
            take_reg         <= '0;
            rd_addr_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end

            if (cmd.count_clear)
            begin
                count_reg <= '0;
            end
            else if (byte_fire && (count_reg != '1))
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.start_init)
            begin
                held_channel_reg <= cid;
                held_command_reg <= hdr_reg[4];
                held_length_reg  <= base_len;
                seq_reg          <= '0;
                elapsed_reg      <= '0;
                collecting_reg   <= 1'b1;
            end
            else if (cmd.go_idle)
            begin
                collecting_reg <= 1'b0;
            end

            if (cmd.start_cont)
            begin
                seq_reg <= seq_reg + 1'b1;
            end

            if (cmd.start_init || cmd.start_cont)
            begin
                take_reg      <= take_next;
                remaining_reg <= remaining_next;
                rd_addr_reg   <= rd_start;
            end
            else if (cmd.rd_step)
            begin
                take_reg    <= take_reg - 1'b1;
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end

            if (cmd.tick_step && collecting_reg)
            begin
                elapsed_reg <= elapsed_next;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_kind_reg       <= cmd.out_kind;
            payload_byte_reg   <= (cmd.out_kind == KIND_PAYLOAD) ? rd_data_reg : 8'h00;
            error_code_reg     <= (cmd.out_kind == KIND_ERROR) ? cmd.out_err : ERR_LENGTH;
            channel_id_reg     <= held_channel_reg;
            frame_command_reg  <= held_command_reg;
            message_length_reg <= held_length_reg;
            last_reg           <= cmd.out_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign payload_byte   = payload_byte_reg;
    assign channel_id     = channel_id_reg;
    assign frame_command  = frame_command_reg;
    assign message_length = message_length_reg;
    assign error_code     = error_code_reg;
    assign last           = last_reg;

`ifndef SYNTHESIS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("Result loaded over a request that was not taken.");

    a_read_within_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_step |-> (take_reg != '0))
        else $error("Buffer read past the end of the frame payload.");

    a_cont_while_collecting: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_cont |-> collecting_reg)
        else $error("Continuation frame started while idle.");

    a_init_sets_collecting: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_init |=> collecting_reg)
        else $error("Init frame did not start a message.");
`endif

endmodule

// ----- sv/ctaphid_ctrl.sv -----
// ============================================================================
// CTAPHID reassembler controller
// Sequences report judging, tick handling, payload draining and the
// completion and error results.
// ============================================================================
module ctaphid_ctrl
    import ctaphid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_command,
    input  logic       in_end,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_TICK,
        ST_FRAME,
        ST_EMIT,
        ST_COMPLETE,
        ST_ERROR
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] err_reg;
    logic [1:0] err_next;

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (in_end)
                    begin
                        state_next = ST_JUDGE;
                    end
                end
            end
            ST_JUDGE:
            begin
                cmd.count_clear = 1'b1;
                if (!status.len_ok)
                begin
                    if (status.collecting)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        err_next   = ERR_LENGTH;
                        state_next = ST_ERROR;
                    end
                end
                else if (!status.collecting)
                begin
                    if (!status.is_init)
                    begin
                        err_next   = ERR_NOT_INIT;
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        cmd.start_init = 1'b1;
                        state_next     = ST_FRAME;
                    end
                end
                else if (!status.cid_match)
                begin
                    state_next = ST_IDLE;
                end
                else if (!status.seq_ok)
                begin
                    cmd.go_idle = 1'b1;
                    err_next    = ERR_SEQUENCE;
                    state_next  = ST_ERROR;
                end
                else
                begin
                    cmd.start_cont = 1'b1;
                    state_next     = ST_FRAME;
                end
            end
            ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (status.collecting && status.timeout_hit)
                begin
                    cmd.go_idle = 1'b1;
                    err_next    = ERR_TIMEOUT;
                    state_next  = ST_ERROR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FRAME:
            begin
                if (!status.take_zero)
                begin
                    cmd.rd_step = 1'b1;
                    state_next  = ST_EMIT;
                end
                else if (status.remaining_zero)
                begin
                    state_next = ST_COMPLETE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = KIND_PAYLOAD;
                    cmd.out_last = status.take_zero && !status.remaining_zero;
                    state_next   = ST_FRAME;
                end
            end
            ST_COMPLETE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = KIND_COMPLETE;
                    cmd.out_last = 1'b1;
                    cmd.go_idle  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_kind = KIND_ERROR;
                    cmd.out_err  = err_reg;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= ERR_LENGTH;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ----- sv/ctaphid_message_reassembler.sv -----
// Timing: a report byte or tick is taken while the controller is idle; a report's last
// byte is judged in the following cycle, and a rejected report's error is offered from
// the error state once the output register is free. Throughput: non-final bytes one per
// cycle while idle; each payload byte is read from the buffer, then loaded into the one
// output register when it is free, and no new report byte or tick is taken meanwhile.
// Reset: rst_n is asynchronous; the buffer is not cleared and needs no clearing pass.
// ============================================================================
// CTAPHID message reassembler
// Buffers received HID reports, checks init and continuation frames, and
// drains the reassembled payload with completion, error and timeout results.
// ============================================================================
module ctaphid_message_reassembler
    import ctaphid_pkg::*;
#(
    parameter int REPORT_BYTES = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ctaphid_in_if.sink           report,
    ctaphid_out_if.source        result,
    input  logic                 cfg_wr_en,
    input  logic [TIMEOUT_W-1:0] cfg_wr_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       in_fire;

    assign report.ready = in_ready;
    assign in_fire      = report.valid && in_ready;

    ctaphid_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (report.valid),
        .in_command (report.command),
        .in_end     (report.report_end),
        .in_ready   (in_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ctaphid_datapath #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .in_command     (report.command),
        .in_byte        (report.report_byte),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .out_kind       (result.out_kind),
        .payload_byte   (result.payload_byte),
        .channel_id     (result.channel_id),
        .frame_command  (result.frame_command),
        .message_length (result.message_length),
        .error_code     (result.error_code),
        .last           (result.last)
    );

endmodule
